FILE: rtl/mpsc_pkg.sv
package mpsc_pkg;

   localparam int WORD_BITS = 64;
   localparam int INDEX_BITS = 20;

   localparam int MODE_BITS = 2;
   localparam int PATTERN_BITS = 8;
   localparam int WORDS_BITS = 21;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_SEL_BITS = 2;

   localparam int CMP_BITS = (INDEX_BITS + 1 > WORDS_BITS) ? INDEX_BITS + 1 : WORDS_BITS;
   localparam int SPREAD_REPS = (WORD_BITS + PATTERN_BITS - 1) / PATTERN_BITS;

   localparam logic [MODE_BITS-1:0] MODE_INCREMENT = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_ZERO_ONE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_PATTERN = 2'd2;

   localparam logic [CSR_SEL_BITS-1:0] REG_TEST_MODE = 2'd0;
   localparam logic [CSR_SEL_BITS-1:0] REG_PATTERN_BYTE = 2'd1;
   localparam logic [CSR_SEL_BITS-1:0] REG_WORDS_IN_USE = 2'd2;

   localparam logic [MODE_BITS-1:0] TEST_MODE_RESET = MODE_INCREMENT;
   localparam logic [PATTERN_BITS-1:0] PATTERN_BYTE_RESET = '0;
   localparam logic [WORDS_BITS-1:0] WORDS_IN_USE_RESET = 21'd1048576;

   typedef struct packed {
      logic [MODE_BITS-1:0] test_mode;
      logic [PATTERN_BITS-1:0] pattern_byte;
      logic [WORDS_BITS-1:0] words_in_use;
   } cfg_type;

endpackage

FILE: rtl/mpsc_csr.sv
module mpsc_csr (
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [mpsc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [mpsc_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [mpsc_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic pready,
   output mpsc_pkg::cfg_type cfg
);
   import mpsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic write_en;
   logic [CSR_SEL_BITS-1:0] sel;

   assign write_en = psel && penable && pwrite;
   assign sel = paddr[CSR_SEL_BITS+1:2];
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (sel)
            REG_TEST_MODE: cfg_in.test_mode = pwdata[MODE_BITS-1:0];
            REG_PATTERN_BYTE: cfg_in.pattern_byte = pwdata[PATTERN_BITS-1:0];
            REG_WORDS_IN_USE: cfg_in.words_in_use = pwdata[WORDS_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         REG_TEST_MODE: prdata = CSR_DATA_BITS'(cfg_ff.test_mode);
         REG_PATTERN_BYTE: prdata = CSR_DATA_BITS'(cfg_ff.pattern_byte);
         REG_WORDS_IN_USE: prdata = CSR_DATA_BITS'(cfg_ff.words_in_use);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.test_mode <= TEST_MODE_RESET;
         cfg_ff.pattern_byte <= PATTERN_BYTE_RESET;
         cfg_ff.words_in_use <= WORDS_IN_USE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/mpsc_core.sv
module mpsc_core (
   input  logic clock,
   input  logic reset,
   input  mpsc_pkg::cfg_type cfg,
   input  logic req_valid,
   output logic req_ready,
   input  logic [mpsc_pkg::WORD_BITS-1:0] req_read_data,
   input  logic req_restart,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [mpsc_pkg::INDEX_BITS-1:0] rsp_word_index,
   output logic rsp_mismatch,
   output logic [mpsc_pkg::WORD_BITS-1:0] rsp_expected_word,
   output logic [mpsc_pkg::WORD_BITS-1:0] rsp_write_word,
   output logic rsp_pass_done
);
   import mpsc_pkg::*;

   logic s1_valid_ff;
   logic s1_valid_in;
   logic [WORD_BITS-1:0] s1_data_ff;
   logic s1_restart_ff;

   logic [INDEX_BITS-1:0] index_ff;
   logic [INDEX_BITS-1:0] index_in;
   logic [WORD_BITS-1:0] expected_ff;
   logic [WORD_BITS-1:0] expected_in;

   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic [INDEX_BITS-1:0] rsp_index_ff;
   logic rsp_mismatch_ff;
   logic [WORD_BITS-1:0] rsp_expected_ff;
   logic [WORD_BITS-1:0] rsp_write_ff;
   logic rsp_done_ff;

   logic advance;
   logic take;
   logic [WORD_BITS-1:0] start_value;
   logic [INDEX_BITS-1:0] idx;
   logic [WORD_BITS-1:0] exp_word;
   logic [WORD_BITS-1:0] wr_word;
   logic [CMP_BITS-1:0] count_next;
   logic last;

   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign take = req_valid && req_ready;

   assign start_value = (cfg.test_mode == MODE_PATTERN)
      ? WORD_BITS'({SPREAD_REPS{cfg.pattern_byte}}) : '0;

   always_comb begin
      if (s1_restart_ff) begin
         idx = '0;
         exp_word = start_value;
      end else begin
         idx = index_ff;
         exp_word = expected_ff;
      end
      if (cfg.test_mode == MODE_INCREMENT) begin
         wr_word = exp_word + WORD_BITS'(1);
      end else begin
         wr_word = ~exp_word;
      end
      count_next = CMP_BITS'(idx) + CMP_BITS'(1);
      last = (idx == {INDEX_BITS{1'b1}}) || (count_next >= CMP_BITS'(cfg.words_in_use));
   end

   always_comb begin
      index_in = index_ff;
      expected_in = expected_ff;
      if (advance) begin
         if (last) begin
            index_in = '0;
            expected_in = wr_word;
         end else begin
            index_in = INDEX_BITS'(count_next);
            expected_in = exp_word;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         index_ff <= '0;
         expected_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         index_ff <= index_in;
         expected_ff <= expected_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_data_ff <= req_read_data;
         s1_restart_ff <= req_restart;
      end
      if (advance) begin
         rsp_index_ff <= idx;
         rsp_mismatch_ff <= (s1_data_ff != exp_word);
         rsp_expected_ff <= exp_word;
         rsp_write_ff <= wr_word;
         rsp_done_ff <= last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word_index = rsp_index_ff;
   assign rsp_mismatch = rsp_mismatch_ff;
   assign rsp_expected_word = rsp_expected_ff;
   assign rsp_write_word = rsp_write_ff;
   assign rsp_pass_done = rsp_done_ff;

endmodule

FILE: rtl/memory_pattern_scrub_checker.sv
// Streaming memory test checker: each request word carries the data read back from the
// current memory word, and each response word gives that word's index, the expected value,
// a mismatch flag, the value to write back for the next pass and a flag marking the last
// word of the pass. One word is accepted every cycle unless the response side stalls, and a
// word accepted into the input register has its response registered in the result register
// once that register is free; the next-word index and expected value are updated as each
// word moves on, so a new word can be taken while the last one is still in flight. Registers
// at byte addresses 0, 4 and 8 hold the test mode, the pattern byte and the number of words
// in a pass, and they should be written only while no words are in flight.
module memory_pattern_scrub_checker (
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [mpsc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [mpsc_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [mpsc_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic pready,
   input  logic req_valid,
   output logic req_ready,
   input  logic [mpsc_pkg::WORD_BITS-1:0] req_read_data,
   input  logic req_restart,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [mpsc_pkg::INDEX_BITS-1:0] rsp_word_index,
   output logic rsp_mismatch,
   output logic [mpsc_pkg::WORD_BITS-1:0] rsp_expected_word,
   output logic [mpsc_pkg::WORD_BITS-1:0] rsp_write_word,
   output logic rsp_pass_done
);
   import mpsc_pkg::*;

   cfg_type cfg;

   mpsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mpsc_core u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_read_data     (req_read_data),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_word_index    (rsp_word_index),
      .rsp_mismatch      (rsp_mismatch),
      .rsp_expected_word (rsp_expected_word),
      .rsp_write_word    (rsp_write_word),
      .rsp_pass_done     (rsp_pass_done)
   );

endmodule

FILE: rtl/mpsc_checker.sv
module mpsc_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [mpsc_pkg::INDEX_BITS-1:0] rsp_word_index,
   input logic [mpsc_pkg::WORD_BITS-1:0] rsp_expected_word,
   input logic [mpsc_pkg::WORD_BITS-1:0] rsp_write_word,
   input logic rsp_pass_done
);
   import mpsc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_index)
         && $stable(rsp_expected_word) && $stable(rsp_pass_done))
      else $error("Response word changed while stalled.");

   a_write_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_write_word == rsp_expected_word + WORD_BITS'(1))
         || (rsp_write_word == ~rsp_expected_word))
      else $error("Write-back word is neither the increment nor the complement.");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word_index == {INDEX_BITS{1'b1}}) |-> rsp_pass_done)
      else $error("Highest index did not end the pass.");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("Request side stalled while no response was pending.");

endmodule

bind memory_pattern_scrub_checker mpsc_checker u_mpsc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_word_index    (rsp_word_index),
   .rsp_expected_word (rsp_expected_word),
   .rsp_write_word    (rsp_write_word),
   .rsp_pass_done     (rsp_pass_done)
);
